### design/wsf_pkg.sv
// ----------------------------------------------------------------------------
// wsf_pkg: shared types and constants for the winnowing shred fingerprint
// Sizes, register indexes, sequencer states and the shared unit's op codes.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package wsf_pkg;

	localparam int MAX_SHRED_DEF         = 32;
	localparam int MAX_WINDOW_DEF        = 32;
	localparam int FILTER_INDEX_BITS_DEF = 15;

	localparam int CFG_W     = 6;
	localparam int CFG_IDX_W = 1;
	localparam int BYTE_W    = 8;
	localparam int HASH_W    = 32;
	localparam int POS_W     = 24;
	localparam int INDEX_W   = 15;

	localparam logic [HASH_W-1:0] DJB2_INIT = 32'd5381;
	localparam logic [POS_W-1:0]  POS_MAX   = {POS_W{1'b1}};

	localparam logic [CFG_W-1:0] SHRED_LEN_RST  = 6'd16;
	localparam logic [CFG_W-1:0] WINDOW_LEN_RST = 6'd12;

	localparam logic [CFG_IDX_W-1:0] REG_SHRED_LENGTH  = 1'b0;
	localparam logic [CFG_IDX_W-1:0] REG_WINDOW_LENGTH = 1'b1;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_HASH,
		ST_PUSH,
		ST_DECIDE,
		ST_SCAN,
		ST_EMIT,
		ST_FIN
	} state_t;

	typedef enum logic {
		ALU_HASH,
		ALU_LE
	} alu_op_t;

	typedef struct packed {
		logic [HASH_W-1:0] sum;
		logic              le;
	} alu_res_t;

endpackage

### design/wsf_alu.sv
// ----------------------------------------------------------------------------
// wsf_alu: shared hash step and compare unit
// One djb2 step (a*33 + byte) or an unsigned a <= b compare.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module wsf_alu (
	input  wsf_pkg::alu_op_t                 op,
	input  logic [wsf_pkg::HASH_W-1:0]       a,
	input  logic [wsf_pkg::HASH_W-1:0]       b,
	input  logic [wsf_pkg::BYTE_W-1:0]       byte_in,
	output wsf_pkg::alu_res_t                res
);
	import wsf_pkg::*;

	always_comb begin
		res.sum = '0;
		res.le  = 1'b0;
		case (op)
			ALU_HASH: res.sum = (a << 5) + a + HASH_W'(byte_in);
			ALU_LE:   res.le  = (a <= b);
			default:  res.sum = '0;
		endcase
	end

endmodule

### design/wsf_history.sv
// ----------------------------------------------------------------------------
// wsf_history: recent byte and shred hash shift lines
// Newest entry at index 0, one read port each, clear on end of section.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module wsf_history #(
	parameter int MAX_SHRED  = wsf_pkg::MAX_SHRED_DEF,
	parameter int MAX_WINDOW = wsf_pkg::MAX_WINDOW_DEF,
	localparam int BIW = (MAX_SHRED  > 1) ? $clog2(MAX_SHRED)  : 1,
	localparam int HIW = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          clr,
	input  logic                          byte_push,
	input  logic [wsf_pkg::BYTE_W-1:0]    byte_in,
	input  logic [BIW-1:0]                byte_idx,
	output logic [wsf_pkg::BYTE_W-1:0]    byte_rd,
	input  logic                          hash_push,
	input  logic [wsf_pkg::HASH_W-1:0]    hash_in,
	input  logic [HIW-1:0]                hash_idx,
	output logic [wsf_pkg::HASH_W-1:0]    hash_rd
);
	import wsf_pkg::*;

	logic [BYTE_W-1:0] bytes_q  [MAX_SHRED];
	logic [HASH_W-1:0] hashes_q [MAX_WINDOW];

	for (genvar i = 0; i < MAX_SHRED; i++) begin : g_byte
		if (i == 0) begin : g_head
			always_ff @(posedge clk or negedge arst_n) begin
				if (!arst_n) begin
					bytes_q[i] <= '0;
				end else if (clr) begin
					bytes_q[i] <= '0;
				end else if (byte_push) begin
					bytes_q[i] <= byte_in;
				end
			end
		end else begin : g_tail
			always_ff @(posedge clk or negedge arst_n) begin
				if (!arst_n) begin
					bytes_q[i] <= '0;
				end else if (clr) begin
					bytes_q[i] <= '0;
				end else if (byte_push) begin
					bytes_q[i] <= bytes_q[i-1];
				end
			end
		end
	end

	for (genvar i = 0; i < MAX_WINDOW; i++) begin : g_hash
		if (i == 0) begin : g_head
			always_ff @(posedge clk or negedge arst_n) begin
				if (!arst_n) begin
					hashes_q[i] <= '0;
				end else if (clr) begin
					hashes_q[i] <= '0;
				end else if (hash_push) begin
					hashes_q[i] <= hash_in;
				end
			end
		end else begin : g_tail
			always_ff @(posedge clk or negedge arst_n) begin
				if (!arst_n) begin
					hashes_q[i] <= '0;
				end else if (clr) begin
					hashes_q[i] <= '0;
				end else if (hash_push) begin
					hashes_q[i] <= hashes_q[i-1];
				end
			end
		end
	end

	assign byte_rd = bytes_q[byte_idx];
	assign hash_rd = hashes_q[hash_idx];

endmodule

### design/winnowing_shred_fingerprint.sv
// ----------------------------------------------------------------------------
// winnowing_shred_fingerprint: djb2 shred hashing with winnowing selection
// One byte per input transaction. Each byte shifts into the history, then a
// shared hash/compare unit forms the djb2 hash of the newest shred_length
// bytes at one byte a cycle and, when no minimum is held or the held minimum
// has aged out of the window, rescans the window at one hash a cycle. Without
// a rescan, a new minimum is emitted when the new hash is not above the held
// one; otherwise nothing is emitted. While no full shred exists yet the byte
// skips hashing. A result waiting in the output register stalls the sequencer
// only when the next result is ready and out_stall is high. A transaction
// marked last_byte clears all section state once it has been processed.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module winnowing_shred_fingerprint #(
	parameter int MAX_SHRED         = wsf_pkg::MAX_SHRED_DEF,
	parameter int MAX_WINDOW        = wsf_pkg::MAX_WINDOW_DEF,
	parameter int FILTER_INDEX_BITS = wsf_pkg::FILTER_INDEX_BITS_DEF
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             cfg_write_en,
	input  logic [wsf_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [wsf_pkg::CFG_W-1:0]        cfg_data,
	input  logic                             in_valid,
	output logic                             in_stall,
	input  logic [wsf_pkg::BYTE_W-1:0]       data_byte,
	input  logic                             last_byte,
	output logic                             out_valid,
	input  logic                             out_stall,
	output logic [wsf_pkg::INDEX_W-1:0]      bit_index,
	output logic [wsf_pkg::HASH_W-1:0]       selected_hash,
	output logic [wsf_pkg::POS_W-1:0]        shred_position
);
	import wsf_pkg::*;

	localparam int LW  = $clog2(MAX_SHRED + 1);
	localparam int WW  = $clog2(MAX_WINDOW + 1);
	localparam int BIW = (MAX_SHRED  > 1) ? $clog2(MAX_SHRED)  : 1;
	localparam int HIW = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
	localparam int P1W = POS_W + 1;

	localparam logic [CFG_W:0]  SHRED_LIM  = MAX_SHRED[CFG_W:0];
	localparam logic [CFG_W:0]  WINDOW_LIM = MAX_WINDOW[CFG_W:0];
	localparam logic [HASH_W-1:0] FILTER_MASK = (HASH_W'(1) << FILTER_INDEX_BITS) - HASH_W'(1);

	// configuration
	logic [CFG_W-1:0] shred_length_q;
	logic [CFG_W-1:0] window_length_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			shred_length_q  <= SHRED_LEN_RST;
			window_length_q <= WINDOW_LEN_RST;
		end else if (cfg_write_en) begin
			unique case (cfg_index)
				REG_SHRED_LENGTH:  shred_length_q  <= cfg_data;
				REG_WINDOW_LENGTH: window_length_q <= cfg_data;
				default:           ;
			endcase
		end
	end

	logic [LW-1:0] len_c;
	logic [WW-1:0] win_c;

	always_comb begin
		if (shred_length_q == '0) begin
			len_c = LW'(1);
		end else if ({1'b0, shred_length_q} > SHRED_LIM) begin
			len_c = LW'(MAX_SHRED);
		end else begin
			len_c = LW'(shred_length_q);
		end
		if (window_length_q == '0) begin
			win_c = WW'(1);
		end else if ({1'b0, window_length_q} > WINDOW_LIM) begin
			win_c = WW'(MAX_WINDOW);
		end else begin
			win_c = WW'(window_length_q);
		end
	end

	// sequencer state and working registers
	state_t            state_q, state_d;
	logic [LW-1:0]     len_q, k_q, k_dec;
	logic [WW-1:0]     win_q, j_q, j_dec, win_dec;
	logic [POS_W-1:0]  pos_q, byte_count_q;
	logic              last_q;
	logic [HASH_W-1:0] h_q, mh_q, cur_hash_q;
	logic [POS_W-1:0]  mp_q, cur_pos_q;
	logic              min_valid_q;

	logic              out_valid_q;
	logic [INDEX_W-1:0] bit_index_q;
	logic [HASH_W-1:0] selected_hash_q;
	logic [POS_W-1:0]  shred_position_q;

	logic              accept;
	logic [P1W-1:0]    acc_p1;
	logic [P1W-1:0]    p1, s_w, s1;
	logic [POS_W-1:0]  s24, first_w;
	logic              window_full, rescan;

	assign accept = in_valid && !in_stall;
	assign acc_p1 = {1'b0, byte_count_q} + P1W'(1);

	assign k_dec   = k_q - LW'(1);
	assign j_dec   = j_q - WW'(1);
	assign win_dec = win_q - WW'(1);

	assign p1          = {1'b0, pos_q} + P1W'(1);
	assign s_w         = p1 - P1W'(len_q);
	assign s24         = s_w[POS_W-1:0];
	assign s1          = {1'b0, s24} + P1W'(1);
	assign window_full = (s1 >= P1W'(win_q));
	assign first_w     = POS_W'(s1 - P1W'(win_q));
	assign rescan      = !min_valid_q || (cur_pos_q < first_w);

	// shared unit and history
	alu_op_t           alu_op;
	logic [HASH_W-1:0] alu_a, alu_b;
	alu_res_t          alu_res;
	logic              hash_push, hist_clr, out_load;
	logic [BIW-1:0]    byte_idx;
	logic [HIW-1:0]    hash_idx;
	logic [BYTE_W-1:0] byte_rd;
	logic [HASH_W-1:0] hash_rd;

	assign byte_idx = k_dec[BIW-1:0];

	wsf_alu u_alu (
		.op      (alu_op),
		.a       (alu_a),
		.b       (alu_b),
		.byte_in (byte_rd),
		.res     (alu_res)
	);

	wsf_history #(
		.MAX_SHRED  (MAX_SHRED),
		.MAX_WINDOW (MAX_WINDOW)
	) u_history (
		.clk       (clk),
		.arst_n    (arst_n),
		.clr       (hist_clr),
		.byte_push (accept),
		.byte_in   (data_byte),
		.byte_idx  (byte_idx),
		.byte_rd   (byte_rd),
		.hash_push (hash_push),
		.hash_in   (h_q),
		.hash_idx  (hash_idx),
		.hash_rd   (hash_rd)
	);

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (accept) begin
					state_d = (acc_p1 >= P1W'(len_c)) ? ST_HASH : ST_FIN;
				end
			end
			ST_HASH: begin
				if (k_q == LW'(1)) begin
					state_d = ST_PUSH;
				end
			end
			ST_PUSH: state_d = ST_DECIDE;
			ST_DECIDE: begin
				if (!window_full) begin
					state_d = ST_FIN;
				end else if (rescan) begin
					state_d = (win_q == WW'(1)) ? ST_EMIT : ST_SCAN;
				end else if (alu_res.le) begin
					state_d = ST_EMIT;
				end else begin
					state_d = ST_FIN;
				end
			end
			ST_SCAN: begin
				if (j_q == WW'(1)) begin
					state_d = ST_EMIT;
				end
			end
			ST_EMIT: begin
				if (out_load) begin
					state_d = ST_FIN;
				end
			end
			ST_FIN:  state_d = ST_IDLE;
			default: state_d = ST_IDLE;
		endcase
	end

	// sequencer outputs
	always_comb begin
		in_stall  = 1'b1;
		alu_op    = ALU_HASH;
		alu_a     = h_q;
		alu_b     = cur_hash_q;
		hash_push = 1'b0;
		hist_clr  = 1'b0;
		out_load  = 1'b0;
		hash_idx  = j_dec[HIW-1:0];
		unique case (state_q)
			ST_IDLE:  in_stall = 1'b0;
			ST_HASH:  alu_op = ALU_HASH;
			ST_PUSH:  hash_push = 1'b1;
			ST_DECIDE: begin
				alu_op   = ALU_LE;
				hash_idx = win_dec[HIW-1:0];
			end
			ST_SCAN: begin
				alu_op = ALU_LE;
				alu_a  = hash_rd;
				alu_b  = mh_q;
			end
			ST_EMIT:  out_load = !out_valid_q || !out_stall;
			ST_FIN:   hist_clr = last_q;
			default:  in_stall = 1'b1;
		endcase
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			byte_count_q <= '0;
			min_valid_q  <= 1'b0;
			out_valid_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			if (accept && (byte_count_q != POS_MAX)) begin
				byte_count_q <= byte_count_q + POS_W'(1);
			end
			if (out_load) begin
				out_valid_q <= 1'b1;
				min_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
			if (hist_clr) begin
				byte_count_q <= '0;
				min_valid_q  <= 1'b0;
			end
		end
	end

	// working registers
	always_ff @(posedge clk) begin
		if (accept) begin
			pos_q  <= byte_count_q;
			len_q  <= len_c;
			win_q  <= win_c;
			last_q <= last_byte;
			k_q    <= len_c;
			h_q    <= DJB2_INIT;
		end
		if (state_q == ST_HASH) begin
			h_q <= alu_res.sum;
			k_q <= k_dec;
		end
		if (state_q == ST_DECIDE) begin
			if (rescan) begin
				mh_q <= hash_rd;
				mp_q <= first_w;
				j_q  <= win_dec;
			end else begin
				mh_q <= h_q;
				mp_q <= s24;
			end
		end
		if (state_q == ST_SCAN) begin
			if (alu_res.le) begin
				mh_q <= hash_rd;
				mp_q <= s24 - POS_W'(j_dec);
			end
			j_q <= j_dec;
		end
		if (out_load) begin
			cur_hash_q       <= mh_q;
			cur_pos_q        <= mp_q;
			bit_index_q      <= mh_q[INDEX_W-1:0] & FILTER_MASK[INDEX_W-1:0];
			selected_hash_q  <= mh_q;
			shred_position_q <= mp_q;
		end
	end

	assign out_valid      = out_valid_q;
	assign bit_index      = bit_index_q;
	assign selected_hash  = selected_hash_q;
	assign shred_position = shred_position_q;

	// checks
	a_out_from_emit: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(state_q == ST_EMIT))
		else $error("result raised outside emit");

	a_hash_count: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_HASH |-> k_q != '0)
		else $error("hash step counter underflow");

	a_section_clear: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_FIN && last_q) |=> (byte_count_q == '0 && !min_valid_q))
		else $error("section state not cleared");

	a_min_age: assert property (@(posedge clk) disable iff (!arst_n)
		min_valid_q |-> cur_pos_q <= byte_count_q)
		else $error("held minimum beyond byte count");

endmodule
